// File: hw/rtl/pfd_pkg.sv
// Shared types and helpers for the popcount FCS deframer.
// Holds the parser phase encoding, the result record and the byte bit count.
// No dependencies.
`default_nettype none

package pfd_pkg;

  typedef enum logic [2:0] {
    PH_CMD  = 3'd0,
    PH_LEN  = 3'd1,
    PH_DATA = 3'd2,
    PH_CHKH = 3'd3,
    PH_CHKL = 3'd4
  } phase_t;

  localparam logic [7:0] CMD_MASK = 8'h7F;
  localparam logic [7:0] LEN_MASK = 8'h3F;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [6:0] command;
    logic [5:0] length;
    logic       check_ok;
    logic       last;
  } pfd_res_t;

  function automatic logic [3:0] bit_count8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'b000, b[k]};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pfd_parser.sv
// Frame parser: phase register, byte counter, running one-bit count and
// header capture. Produces at most one result per accepted byte.
// Depends on pfd_pkg.
`default_nettype none

module pfd_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [7:0]       rx_byte,
  input  wire logic             frame_start,
  output pfd_pkg::pfd_res_t     res,
  output logic                  res_valid
);
  import pfd_pkg::*;

  phase_t     phase_r,        phase_nxt;
  logic [5:0] remaining_r,    remaining_nxt;
  logic [9:0] ones_count_r,   ones_count_nxt;
  logic [6:0] held_command_r, held_command_nxt;
  logic [5:0] held_length_r,  held_length_nxt;
  logic [7:0] check_high_r,   check_high_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_CMD;
      remaining_r    <= '0;
      ones_count_r   <= '0;
      held_command_r <= '0;
      held_length_r  <= '0;
      check_high_r   <= '0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      remaining_r    <= remaining_nxt;
      ones_count_r   <= ones_count_nxt;
      held_command_r <= held_command_nxt;
      held_length_r  <= held_length_nxt;
      check_high_r   <= check_high_nxt;
    end
  end

  always_comb begin
    logic [3:0]  bits;
    logic [9:0]  sum;
    logic [5:0]  rem_dec;
    phase_t      ph;

    bits    = bit_count8(rx_byte);
    sum     = ones_count_r + {6'd0, bits};
    rem_dec = remaining_r - 6'd1;
    // start marker resyncs regardless of where we are
    ph      = frame_start ? PH_CMD : phase_r;

    phase_nxt        = phase_r;
    remaining_nxt    = remaining_r;
    ones_count_nxt   = ones_count_r;
    held_command_nxt = held_command_r;
    held_length_nxt  = held_length_r;
    check_high_nxt   = check_high_r;

    res_valid     = 1'b0;
    res.kind      = KIND_DATA;
    res.data_byte = '0;
    res.command   = held_command_r;
    res.length    = held_length_r;
    res.check_ok  = 1'b0;
    res.last      = 1'b0;

    case (ph)
      PH_LEN: begin
        held_length_nxt = rx_byte[5:0] & LEN_MASK[5:0];
        remaining_nxt   = rx_byte[5:0] & LEN_MASK[5:0];
        ones_count_nxt  = sum;
        phase_nxt       = (rx_byte[5:0] == 6'd0) ? PH_CHKH : PH_DATA;
      end
      PH_DATA: begin
        ones_count_nxt = sum;
        remaining_nxt  = rem_dec;
        if (rem_dec == 6'd0) begin
          phase_nxt = PH_CHKH;
        end
        res_valid     = 1'b1;
        res.data_byte = rx_byte;
      end
      PH_CHKH: begin
        check_high_nxt = rx_byte;
        phase_nxt      = PH_CHKL;
      end
      PH_CHKL: begin
        res_valid    = 1'b1;
        res.kind     = KIND_END;
        res.last     = 1'b1;
        res.check_ok = ({check_high_r, rx_byte} == {6'd0, ones_count_r});
        phase_nxt    = PH_CMD;
      end
      default: begin
        // command byte; also covers unused phase codes
        held_command_nxt = rx_byte[6:0] & CMD_MASK[6:0];
        held_length_nxt  = '0;
        remaining_nxt    = '0;
        check_high_nxt   = '0;
        ones_count_nxt   = {6'd0, bits};
        phase_nxt        = PH_LEN;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/pfd_outbuf.sv
// Two-entry output buffer: result register plus skid register, so the
// input side can take one more result while the receiver stalls.
// Depends on pfd_pkg.
`default_nettype none

module pfd_outbuf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire pfd_pkg::pfd_res_t push_res,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pfd_pkg::pfd_res_t      out_res
);
  import pfd_pkg::*;

  logic     main_vld_r,  main_vld_nxt;
  logic     skid_vld_r,  skid_vld_nxt;
  pfd_res_t main_r,      main_nxt;
  pfd_res_t skid_r,      skid_nxt;
  logic     pop;
  logic     main_free;

  assign pop       = main_vld_r && !out_stall;
  assign main_free = !main_vld_r || pop;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (main_free) begin
      if (skid_vld_r) begin
        main_vld_nxt = 1'b1;
        main_nxt     = skid_r;
        skid_vld_nxt = push;
        skid_nxt     = push_res;
      end else begin
        main_vld_nxt = push;
        main_nxt     = push_res;
      end
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_res   = main_r;

endmodule

`default_nettype wire

// File: hw/rtl/popcount_fcs_deframer.sv
// Popcount FCS deframer: receives a length-prefixed frame a byte at a time,
// passes data bytes out and reports the command, length and check result.
//
// Input channel (in_valid / in_stall): one frame byte per transaction.
//   in_frame_start marks a command byte and drops any frame in progress.
// Output channel (out_valid / out_stall): one result per data byte and one
//   end-of-frame result (out_kind = 1, out_last = 1) after the low check byte.
//   Command, length and check bytes other than the last give no result.
// Latency: with the output free, a result is presented the cycle after its
//   byte is accepted.
// Throughput: one byte per cycle while in_stall is low; the parser state
//   updates in one pass of an 8-bit bit count plus a 10-bit add.
// Stall: results go to a result register backed by a skid register.
//   in_stall rises only once the skid register holds a result, so bytes that
//   give no result keep flowing and one more result is taken after the
//   receiver starts stalling. in_stall is registered.
// Reset (rst_n low, synchronous): parser waits for a command byte, counts
//   cleared, output buffer empty, in_stall low.
`default_nettype none

module popcount_fcs_deframer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_frame_start,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_kind,
  output logic [7:0]      out_data_byte,
  output logic [6:0]      out_command,
  output logic [5:0]      out_length,
  output logic            out_check_ok,
  output logic            out_last
);
  import pfd_pkg::*;

  logic     accept;
  logic     res_valid;
  logic     full;
  pfd_res_t res;
  pfd_res_t out_res;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  pfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .rx_byte     (in_rx_byte),
    .frame_start (in_frame_start),
    .res         (res),
    .res_valid   (res_valid)
  );

  pfd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_res  (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind      = out_res.kind;
  assign out_data_byte = out_res.data_byte;
  assign out_command   = out_res.command;
  assign out_length    = out_res.length;
  assign out_check_ok  = out_res.check_ok;
  assign out_last      = out_res.last;

endmodule

`default_nettype wire

// File: hw/rtl/pfd_checker.sv
// Port-level checks for the popcount FCS deframer, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module pfd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_kind,
  input wire logic [7:0] out_data_byte,
  input wire logic       out_check_ok,
  input wire logic       out_last
);

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_kind))
    else $error("last flag disagrees with kind");

  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> !out_check_ok)
    else $error("check flag set on a data result");

  a_end_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> (out_data_byte == 8'd0))
    else $error("data byte nonzero on end result");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_byte)
      && $stable(out_kind))
    else $error("stalled result changed");

endmodule

bind popcount_fcs_deframer pfd_checker u_pfd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_kind      (out_kind),
  .out_data_byte (out_data_byte),
  .out_check_ok  (out_check_ok),
  .out_last      (out_last)
);

`default_nettype wire

// File: test/tb_popcount_fcs_deframer.sv
// Self-checking testbench for popcount_fcs_deframer: frames with random content,
// broken frames and noise bytes, checked against an in-bench frame parser.
// Depends on pfd_pkg (phase encoding, result record, kind codes) and the RTL top.
`default_nettype none

module tb_popcount_fcs_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import pfd_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       s;
  } rx_item_t;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic [7:0] in_rx_byte     = 8'h00;
  logic       in_frame_start = 1'b0;
  logic       out_stall      = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       out_kind;
  logic [7:0] out_data_byte;
  logic [6:0] out_command;
  logic [5:0] out_length;
  logic       out_check_ok;
  logic       out_last;

  popcount_fcs_deframer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_command    (out_command),
    .out_length     (out_length),
    .out_check_ok   (out_check_ok),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  rx_item_t rx_bytes_q[$];
  pfd_res_t frame_results_q[$];
  rx_item_t next_item;

  int   bytes_taken   = 0;
  int   results_seen  = 0;
  int   mismatch_cnt  = 0;
  int   send_gap      = 0;
  int   rcv_gap       = 0;
  logic hold_off      = 1'b0;

  // parser state mirror
  phase_t     parse_ph  = PH_CMD;
  logic [5:0] left_q    = '0;
  logic [9:0] ones_q    = '0;
  logic [6:0] cmd_q     = '0;
  logic [5:0] len_q     = '0;
  logic [7:0] chk_hi_q  = '0;

  function automatic logic [9:0] ones_in(input logic [7:0] b);
    ones_in = 10'($countones(b));
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic s);
    phase_t   ph;
    pfd_res_t r;
    ph = s ? PH_CMD : parse_ph;
    r  = '0;
    case (ph)
      PH_LEN: begin
        len_q    = b[5:0];
        left_q   = b[5:0];
        ones_q   = ones_q + ones_in(b);
        parse_ph = (b[5:0] == 6'd0) ? PH_CHKH : PH_DATA;
      end
      PH_DATA: begin
        ones_q  = ones_q + ones_in(b);
        left_q  = left_q - 6'd1;
        if (left_q == 6'd0) parse_ph = PH_CHKH;
        r.kind      = KIND_DATA;
        r.data_byte = b;
        r.command   = cmd_q;
        r.length    = len_q;
        frame_results_q.push_back(r);
      end
      PH_CHKH: begin
        chk_hi_q = b;
        parse_ph = PH_CHKL;
      end
      PH_CHKL: begin
        r.kind     = KIND_END;
        r.command  = cmd_q;
        r.length   = len_q;
        r.check_ok = ({chk_hi_q, b} == {6'd0, ones_q});
        r.last     = 1'b1;
        frame_results_q.push_back(r);
        parse_ph = PH_CMD;
      end
      default: begin
        // command byte, with or without the start marker
        cmd_q    = b[6:0];
        len_q    = '0;
        left_q   = '0;
        chk_hi_q = '0;
        ones_q   = ones_in(b);
        parse_ph = PH_LEN;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_cnt++;
    if (mismatch_cnt <= 40)
      $display("%0t mismatch on %s: got %0d, expected %0d (result %0d)",
               $realtime, what, got, want, results_seen);
  endtask

  task automatic check_result();
    pfd_res_t want;
    if (frame_results_q.size() == 0) begin
      report_mismatch("unexpected result, kind", int'(out_kind), -1);
      return;
    end
    want = frame_results_q.pop_front();
    if (out_kind !== want.kind)
      report_mismatch("kind", int'(out_kind), int'(want.kind));
    if (out_data_byte !== want.data_byte)
      report_mismatch("data_byte", int'(out_data_byte), int'(want.data_byte));
    if (out_command !== want.command)
      report_mismatch("command", int'(out_command), int'(want.command));
    if (out_length !== want.length)
      report_mismatch("length", int'(out_length), int'(want.length));
    if (out_check_ok !== want.check_ok)
      report_mismatch("check_ok", int'(out_check_ok), int'(want.check_ok));
    if (out_last !== want.last)
      report_mismatch("last", int'(out_last), int'(want.last));
  endtask

  // Driver: one transaction per accepted byte, random idle bursts except in quiet stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(in_rx_byte, in_frame_start);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (rx_bytes_q.size() > 0) begin
          next_item = rx_bytes_q.pop_front();
          in_valid       <= 1'b1;
          in_rx_byte     <= next_item.b;
          in_frame_start <= next_item.s;
          if (rx_bytes_q.size() > 120 && (bytes_taken / 50) % 4 != 3 &&
              $urandom_range(0, 5) == 0)
            send_gap = $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result and drives the receiver stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result();
        results_seen++;
      end
      if (rcv_gap > 0)
        rcv_gap--;
      else if (rx_bytes_q.size() > 120 && (results_seen / 40) % 4 != 3 &&
               $urandom_range(0, 7) == 0)
        rcv_gap = $urandom_range(1, 3);
      out_stall <= hold_off || (rcv_gap > 0);
    end
  end

  // Long receiver hold-off while the sender keeps offering bytes.
  initial begin
    wait (bytes_taken >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (60) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic push_byte(input logic [7:0] b, input logic s);
    rx_item_t it;
    it.b = b;
    it.s = s;
    rx_bytes_q.push_back(it);
  endtask

  // keep = 0 sends the whole frame, otherwise only its first keep bytes
  task automatic add_frame(input logic [7:0] cmd_b, input logic [7:0] len_b,
                           input logic lead, input logic bad, input int keep);
    rx_item_t    f[$];
    rx_item_t    it;
    logic [15:0] chk;
    logic [7:0]  d;
    int          n;
    n   = int'(len_b[5:0]);
    chk = 16'($countones(cmd_b) + $countones(len_b));
    it.b = cmd_b; it.s = lead; f.push_back(it);
    it.b = len_b; it.s = 1'b0; f.push_back(it);
    for (int i = 0; i < n; i++) begin
      d   = 8'($urandom);
      chk = chk + 16'($countones(d));
      it.b = d; f.push_back(it);
    end
    if (bad) begin
      if ($urandom_range(0, 1) == 0) chk = chk ^ (16'd1 << $urandom_range(0, 15));
      else chk = 16'($urandom);
    end
    it.b = chk[15:8]; f.push_back(it);
    it.b = chk[7:0];  f.push_back(it);
    if (keep == 0) keep = f.size();
    for (int i = 0; i < keep; i++) rx_bytes_q.push_back(f[i]);
  endtask

  initial begin
    int         sel;
    int         ln;
    logic [7:0] len_b;

    // zero length frame, all-zero bytes, check passes
    push_byte(8'h00, 1'b1); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    // command without start marker, masked high bits, check 19 = 8 + 3 + 8
    push_byte(8'hFF, 1'b0); push_byte(8'hC1, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h13, 1'b0);
    // start marker mid-data drops the frame; nonzero high check byte fails
    push_byte(8'h55, 1'b1); push_byte(8'h02, 1'b0); push_byte(8'hAA, 1'b0);
    push_byte(8'h7F, 1'b1); push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0); push_byte(8'h07, 1'b0);
    // start marker on the low check byte position
    push_byte(8'h01, 1'b1); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h02, 1'b1); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);

    while (rx_bytes_q.size() < 850) begin
      sel = $urandom_range(0, 99);
      ln  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 63) : $urandom_range(0, 8);
      if (sel == 0) ln = 63;
      len_b      = 8'($urandom);
      len_b[5:0] = 6'(ln);
      if (sel < 78)
        add_frame(8'($urandom), len_b, $urandom_range(0, 5) != 0,
                  $urandom_range(0, 4) == 0, 0);
      else if (sel < 90)
        add_frame(8'($urandom), len_b, 1'b1, 1'b0, $urandom_range(1, ln + 3));
      else
        repeat ($urandom_range(1, 4))
          push_byte(8'($urandom), 1'($urandom_range(0, 1)));
    end
    add_frame(8'h3C, 8'h02, 1'b1, 1'b0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (rx_bytes_q.size() != 0 || in_valid || frame_results_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("** popcount_fcs_deframer: PASSED **");
    else
      $display("** popcount_fcs_deframer: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("** popcount_fcs_deframer: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/pfd_pkg.sv
hw/rtl/pfd_parser.sv
hw/rtl/pfd_outbuf.sv
hw/rtl/popcount_fcs_deframer.sv
hw/rtl/pfd_checker.sv
test/tb_popcount_fcs_deframer.sv
